// ===== rtl/sfrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfrs_pkg;

  // Frame phase of the sequencer
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  // Request codes carried on in_op
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_READ_ID   = 2'd1,
    OP_READ_DATA = 2'd2,
    OP_RSVD      = 2'd3
  } op_t;

  localparam logic [7:0] CMD_READ_ID   = 8'h90;
  localparam logic [7:0] CMD_READ_DATA = 8'h03;
  localparam logic [7:0] FILL_ID       = 8'h00;
  localparam logic [7:0] FILL_DATA     = 8'hFF;

  // Header bytes that follow the command byte (three address bytes)
  localparam logic [1:0] HDR_BYTES     = 2'd3;
  localparam logic [15:0] ID_BYTES     = 16'd2;

endpackage

`default_nettype wire

// ===== rtl/spi_flash_read_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// SPI mode-3 read sequencer for a serial NOR flash. Every input word is one
// half-bit tick: it carries the sampled MISO level and, while no frame is
// running, an optional request (read ID: 0x90 + three zero bytes, then two
// ID bytes; read data: 0x03 + 24-bit address, then in_byte_count bytes).
// Every accepted word yields exactly one output word with the pin levels
// for that tick (chip select, SCLK, MOSI), the received byte strobe and the
// busy flag. A bit spans two ticks: drive MOSI with SCLK low, then raise
// SCLK; MISO is sampled on the tick after that, which also drives the next
// bit or closes the frame. A byte is sixteen ticks.
// Requests that arrive during a frame, including on its closing tick, are
// dropped. Throughput is one word per clock unless out_stall holds the
// output register, which presents each word in the cycle after it is taken.
// in_stall follows out_stall only while that register holds an untaken word.
module spi_flash_read_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [23:0] in_flash_addr,
  input  wire logic [15:0] in_byte_count,
  input  wire logic        in_miso_level,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_chip_select_n,
  output logic             out_serial_clock,
  output logic             out_mosi_level,
  output logic [7:0]       out_rx_byte,
  output logic             out_rx_valid,
  output logic             out_rx_last,
  output logic             out_busy_res
);

  // Sequencer state
  sfrs_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic        half_select_r, half_select_nxt;   // 1: next tick raises SCLK
  logic [7:0]  tx_shift_r, tx_shift_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;
  logic [1:0]  hdr_left_r, hdr_left_nxt;
  logic [23:0] addr_latch_r, addr_latch_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        mode_is_id_r, mode_is_id_nxt;
  logic        mosi_hold_r, mosi_hold_nxt;

  // Output register
  logic        out_valid_r;
  logic        cs_n_r, sclk_r, mosi_r, rx_valid_r, rx_last_r, busy_r;
  logic [7:0]  rx_byte_r;

  logic        accept;
  logic        rx_valid_nxt, rx_last_nxt, frame_end;
  logic [7:0]  rx_byte_nxt, rx_sample, addr_byte;
  logic [15:0] bytes_dec;
  sfrs_pkg::op_t op;

  // Output register is free when empty or drained this cycle
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign op       = sfrs_pkg::op_t'(in_op);

  assign rx_sample = {rx_shift_r[6:0], in_miso_level};
  assign bytes_dec = bytes_left_r - 16'd1;

  // Address byte to send next, MSB first
  always_comb begin
    unique case (hdr_left_r)
      2'd3:    addr_byte = addr_latch_r[23:16];
      2'd2:    addr_byte = addr_latch_r[15:8];
      2'd1:    addr_byte = addr_latch_r[7:0];
      default: addr_byte = 8'h00;
    endcase
  end

  always_comb begin
    phase_nxt       = phase_r;
    bit_index_nxt   = bit_index_r;
    half_select_nxt = half_select_r;
    tx_shift_nxt    = tx_shift_r;
    rx_shift_nxt    = rx_shift_r;
    hdr_left_nxt    = hdr_left_r;
    addr_latch_nxt  = addr_latch_r;
    bytes_left_nxt  = bytes_left_r;
    mode_is_id_nxt  = mode_is_id_r;
    mosi_hold_nxt   = mosi_hold_r;
    rx_byte_nxt     = 8'h00;
    rx_valid_nxt    = 1'b0;
    rx_last_nxt     = 1'b0;
    frame_end       = 1'b0;

    if (phase_r != sfrs_pkg::PH_HEADER && phase_r != sfrs_pkg::PH_DATA) begin
      phase_nxt = sfrs_pkg::PH_IDLE;
      if (op == sfrs_pkg::OP_READ_ID || op == sfrs_pkg::OP_READ_DATA) begin
        mode_is_id_nxt  = (op == sfrs_pkg::OP_READ_ID);
        addr_latch_nxt  = (op == sfrs_pkg::OP_READ_ID) ? 24'h000000 : in_flash_addr;
        bytes_left_nxt  = (op == sfrs_pkg::OP_READ_ID) ? sfrs_pkg::ID_BYTES
                                                       : in_byte_count;
        hdr_left_nxt    = sfrs_pkg::HDR_BYTES;
        rx_shift_nxt    = 8'h00;
        phase_nxt       = sfrs_pkg::PH_HEADER;
        tx_shift_nxt    = (op == sfrs_pkg::OP_READ_ID) ? sfrs_pkg::CMD_READ_ID
                                                       : sfrs_pkg::CMD_READ_DATA;
        bit_index_nxt   = 3'd0;
        mosi_hold_nxt   = tx_shift_nxt[7];
        half_select_nxt = 1'b1;
      end
    end else if (half_select_r) begin
      half_select_nxt = 1'b0;
    end else begin
      // Sample tick: end of the high half
      rx_shift_nxt = rx_sample;
      if (bit_index_r != 3'd7) begin
        bit_index_nxt   = bit_index_r + 3'd1;
        mosi_hold_nxt   = tx_shift_r[~bit_index_nxt];
        half_select_nxt = 1'b1;
      end else begin
        if (phase_r == sfrs_pkg::PH_DATA) begin
          rx_byte_nxt    = rx_sample;
          rx_valid_nxt   = 1'b1;
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == 16'd0) begin
            rx_last_nxt = 1'b1;
            frame_end   = 1'b1;
          end
        end else if (hdr_left_r != 2'd0) begin
          hdr_left_nxt    = hdr_left_r - 2'd1;
          tx_shift_nxt    = addr_byte;
          bit_index_nxt   = 3'd0;
          mosi_hold_nxt   = addr_byte[7];
          half_select_nxt = 1'b1;
        end else begin
          phase_nxt = sfrs_pkg::PH_DATA;
          frame_end = (bytes_left_r == 16'd0);
        end

        if (frame_end) begin
          phase_nxt       = sfrs_pkg::PH_IDLE;
          half_select_nxt = 1'b0;
          bit_index_nxt   = 3'd0;
        end else if (phase_nxt == sfrs_pkg::PH_DATA) begin
          // Dummy byte clocked out while the flash returns data
          tx_shift_nxt    = mode_is_id_r ? sfrs_pkg::FILL_ID : sfrs_pkg::FILL_DATA;
          bit_index_nxt   = 3'd0;
          mosi_hold_nxt   = tx_shift_nxt[7];
          half_select_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= sfrs_pkg::PH_IDLE;
      bit_index_r   <= 3'd0;
      half_select_r <= 1'b0;
      tx_shift_r    <= 8'h00;
      rx_shift_r    <= 8'h00;
      hdr_left_r    <= 2'd0;
      addr_latch_r  <= 24'h000000;
      bytes_left_r  <= 16'h0000;
      mode_is_id_r  <= 1'b0;
      mosi_hold_r   <= 1'b1;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      bit_index_r   <= bit_index_nxt;
      half_select_r <= half_select_nxt;
      tx_shift_r    <= tx_shift_nxt;
      rx_shift_r    <= rx_shift_nxt;
      hdr_left_r    <= hdr_left_nxt;
      addr_latch_r  <= addr_latch_nxt;
      bytes_left_r  <= bytes_left_nxt;
      mode_is_id_r  <= mode_is_id_nxt;
      mosi_hold_r   <= mosi_hold_nxt;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cs_n_r     <= (phase_nxt == sfrs_pkg::PH_IDLE);
      sclk_r     <= (phase_nxt == sfrs_pkg::PH_IDLE) | ~half_select_nxt;
      mosi_r     <= mosi_hold_nxt;
      rx_byte_r  <= rx_byte_nxt;
      rx_valid_r <= rx_valid_nxt;
      rx_last_r  <= rx_last_nxt;
      busy_r     <= (phase_nxt != sfrs_pkg::PH_IDLE);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chip_select_n = cs_n_r;
  assign out_serial_clock  = sclk_r;
  assign out_mosi_level    = mosi_r;
  assign out_rx_byte       = rx_byte_r;
  assign out_rx_valid      = rx_valid_r;
  assign out_rx_last       = rx_last_r;
  assign out_busy_res      = busy_r;

endmodule

`default_nettype wire
